@@ src/rrga_pkg.sv @@
// Shared types, constants and helpers for the rectangle region RGB averager.
package rrga_pkg;

  // Largest image dimension and the derived position width
  localparam int MAX_DIM = 2048;
  localparam int DIM_W   = $clog2(MAX_DIM);

  // Fixed field widths
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 12;
  localparam int LEFT_W  = 11;
  localparam int SUM_W   = 30;
  localparam int CNT_W   = 2 * CFG_W;
  localparam int POS_W   = 14;
  localparam int NCH     = 3;
  localparam int STEP_W  = $clog2(SUM_W);

  // Job queue depth
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  // Configuration register indexes
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_RECT_LEFT    = 3'd2;
  localparam logic [IDX_W-1:0] REG_RECT_TOP     = 3'd3;
  localparam logic [IDX_W-1:0] REG_RECT_WIDTH   = 3'd4;
  localparam logic [IDX_W-1:0] REG_RECT_HEIGHT  = 3'd5;

  // Register values after reset
  localparam logic [CFG_W-1:0]  RST_IMAGE_WIDTH  = 12'd2048;
  localparam logic [CFG_W-1:0]  RST_IMAGE_HEIGHT = 12'd2048;
  localparam logic [LEFT_W-1:0] RST_RECT_LEFT    = 11'd0;
  localparam logic [LEFT_W-1:0] RST_RECT_TOP     = 11'd0;
  localparam logic [CFG_W-1:0]  RST_RECT_WIDTH   = 12'd2;
  localparam logic [CFG_W-1:0]  RST_RECT_HEIGHT  = 12'd1;

  typedef struct packed {
    logic [CFG_W-1:0]  image_width;
    logic [CFG_W-1:0]  image_height;
    logic [LEFT_W-1:0] rect_left;
    logic [LEFT_W-1:0] rect_top;
    logic [CFG_W-1:0]  rect_width;
    logic [CFG_W-1:0]  rect_height;
  } cfg_t;

  // One finished frame waiting for division
  typedef struct packed {
    logic [NCH-1:0][SUM_W-1:0] sums;
    logic [CNT_W-1:0]          count;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } back_st_t;

  // Zero reads as one, anything above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W:0] ve;
    logic [DIM_W:0] res;
    ve = {1'b0, v};
    if (v == '0) begin
      res = (DIM_W+1)'(1);
    end else if (ve > (CFG_W+1)'(MAX_DIM)) begin
      res = (DIM_W+1)'(MAX_DIM);
    end else begin
      res = (DIM_W+1)'(v);
    end
    return res;
  endfunction

  // Odd width goes down by one, width of one becomes two
  function automatic logic [CFG_W-1:0] even_width(input logic [CFG_W-1:0] w);
    logic [CFG_W-1:0] res;
    if (w[0]) begin
      res = (w == CFG_W'(1)) ? CFG_W'(2) : w - CFG_W'(1);
    end else begin
      res = w;
    end
    return res;
  endfunction

endpackage

@@ src/rrga_front.sv @@
// Raster position tracking, rectangle test and per-channel accumulation.
module rrga_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rrga_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  input  logic [rrga_pkg::PIX_W-1:0]  in_red,
  input  logic [rrga_pkg::PIX_W-1:0]  in_green,
  input  logic [rrga_pkg::PIX_W-1:0]  in_blue,
  output logic                        in_stall,
  input  logic                        q_full,
  output logic                        q_push,
  output rrga_pkg::job_t              q_job
);
  import rrga_pkg::*;

  logic [DIM_W-1:0]            col_r, col_nxt;
  logic [DIM_W-1:0]            row_r, row_nxt;
  logic [NCH-1:0][SUM_W-1:0]   sum_r, sum_nxt;
  logic [NCH-1:0][SUM_W-1:0]   sum_add;
  logic [NCH-1:0][PIX_W-1:0]   pix;
  logic [DIM_W:0]              img_w, img_h;
  logic [CFG_W-1:0]            adj_w;
  logic [POS_W-1:0]            col_e, row_e;
  logic                        in_rect;
  logic                        accept;
  logic                        col_wrap, frame_end;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign pix      = {in_blue, in_green, in_red};

  assign img_w = clamp_dim(cfg.image_width);
  assign img_h = clamp_dim(cfg.image_height);
  assign adj_w = even_width(cfg.rect_width);

  // Rectangle membership of the current pixel
  assign col_e   = POS_W'(col_r);
  assign row_e   = POS_W'(row_r);
  assign in_rect = (col_e >= POS_W'(cfg.rect_left)) &&
                   (col_e <  POS_W'(cfg.rect_left) + POS_W'(adj_w)) &&
                   (row_e >= POS_W'(cfg.rect_top)) &&
                   (row_e <  POS_W'(cfg.rect_top) + POS_W'(cfg.rect_height));

  // Position advance
  assign col_wrap  = ({1'b0, col_r} + (DIM_W+1)'(1)) >= img_w;
  assign frame_end = col_wrap && (({1'b0, row_r} + (DIM_W+1)'(1)) >= img_h);

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      sum_add[i] = in_rect ? sum_r[i] + SUM_W'(pix[i]) : sum_r[i];
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    sum_nxt = sum_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + DIM_W'(1);
      end else begin
        col_nxt = col_r + DIM_W'(1);
      end
      sum_nxt = frame_end ? '0 : sum_add;
    end
  end

  // Frame result goes to the queue together with the divisor
  assign q_push      = accept && frame_end;
  assign q_job.sums  = sum_add;
  assign q_job.count = CNT_W'(adj_w) * CNT_W'(cfg.rect_height);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      sum_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

@@ src/rrga_queue.sv @@
// Short job queue between the accumulator and the divider.
module rrga_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rrga_pkg::job_t push_job,
  input  logic           pop,
  output rrga_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);
  import rrga_pkg::*;

  job_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt;
  logic [QPTR_W-1:0]   rp_r, rp_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH-1)) ? '0 : wp_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH-1)) ? '0 : rp_r + QPTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + (QPTR_W+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (QPTR_W+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule

@@ src/rrga_back.sv @@
// Bit-serial divider for the three channel sums and the result register.
module rrga_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  rrga_pkg::job_t              q_job,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rrga_pkg::PIX_W-1:0]  out_avg_red,
  output logic [rrga_pkg::PIX_W-1:0]  out_avg_green,
  output logic [rrga_pkg::PIX_W-1:0]  out_avg_blue,
  output logic                        out_empty_region
);
  import rrga_pkg::*;

  back_st_t                  state_r, state_nxt;
  logic [NCH-1:0][SUM_W-1:0] quo_r, quo_nxt;
  logic [NCH-1:0][CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]          div_r, div_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      empty_r, empty_nxt;
  logic [NCH-1:0][CNT_W:0]   rem_sh;
  logic [NCH-1:0]            fits;

  // One restoring step per channel
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      rem_sh[i] = {rem_r[i], quo_r[i][SUM_W-1]};
      fits[i]   = rem_sh[i] >= {1'b0, div_r};
    end
  end

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    step_nxt  = step_r;
    empty_nxt = empty_r;
    q_pop     = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          rem_nxt = '0;
          div_nxt = q_job.count;
          step_nxt = '0;
          if (q_job.count == '0) begin
            quo_nxt   = '0;
            empty_nxt = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            quo_nxt   = q_job.sums;
            empty_nxt = 1'b0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        for (int i = 0; i < NCH; i++) begin
          rem_nxt[i] = fits[i] ? CNT_W'(rem_sh[i] - {1'b0, div_r}) : CNT_W'(rem_sh[i]);
          quo_nxt[i] = {quo_r[i][SUM_W-2:0], fits[i]};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W-1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_avg_red      = quo_r[0][PIX_W-1:0];
  assign out_avg_green    = quo_r[1][PIX_W-1:0];
  assign out_avg_blue     = quo_r[2][PIX_W-1:0];
  assign out_empty_region = empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    step_r  <= step_nxt;
    empty_r <= empty_nxt;
  end

endmodule

@@ src/rect_region_rgb_average.sv @@
// Result path: after a frame's last pixel is accepted, its job is loaded from the
//   queue, then 30 divider steps of one quotient bit each yield the offered result.
// Throughput: one pixel per cycle unless the two-entry job queue is full, which
//   absorbs back-to-back frames; the divider waits for each result to be taken.
// Reset: synchronous, active low; clears position counters, sums, queue and
//   divider state, and loads configuration defaults.
module rect_region_rgb_average (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rrga_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rrga_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rrga_pkg::PIX_W-1:0]  in_red,
  input  logic [rrga_pkg::PIX_W-1:0]  in_green,
  input  logic [rrga_pkg::PIX_W-1:0]  in_blue,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rrga_pkg::PIX_W-1:0]  out_avg_red,
  output logic [rrga_pkg::PIX_W-1:0]  out_avg_green,
  output logic [rrga_pkg::PIX_W-1:0]  out_avg_blue,
  output logic                        out_empty_region
);
  import rrga_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  job_t push_job, pop_job;
  logic q_push, q_pop, q_full, q_empty;

  // Configuration register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_wdata;
        REG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_wdata;
        REG_RECT_LEFT:    cfg_nxt.rect_left    = cfg_wdata[LEFT_W-1:0];
        REG_RECT_TOP:     cfg_nxt.rect_top     = cfg_wdata[LEFT_W-1:0];
        REG_RECT_WIDTH:   cfg_nxt.rect_width   = cfg_wdata;
        REG_RECT_HEIGHT:  cfg_nxt.rect_height  = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= RST_IMAGE_WIDTH;
      cfg_r.image_height <= RST_IMAGE_HEIGHT;
      cfg_r.rect_left    <= RST_RECT_LEFT;
      cfg_r.rect_top     <= RST_RECT_TOP;
      cfg_r.rect_width   <= RST_RECT_WIDTH;
      cfg_r.rect_height  <= RST_RECT_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rrga_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  rrga_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  rrga_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_job            (pop_job),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_avg_red      (out_avg_red),
    .out_avg_green    (out_avg_green),
    .out_avg_blue     (out_avg_blue),
    .out_empty_region (out_empty_region)
  );

`ifndef SYNTHESIS
  // A finished frame is never pushed into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("job pushed into full queue");

  // An empty region always reports zero averages
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_region) |->
      (out_avg_red == '0 && out_avg_green == '0 && out_avg_blue == '0))
    else $error("empty region with nonzero average");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid) else $error("result valid after reset");

  // The divider takes a job only while no result is pending
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_valid && !q_empty)) else $error("pop while busy");
`endif

endmodule
